[src/dfs_traversal_adjacency_matrix_defines.svh]
// ----------------------------------------------------------------------------
// dfs_traversal_adjacency_matrix_defines.svh
// Assertion macros for the depth-first traversal block.
// ----------------------------------------------------------------------------
`ifndef DFS_TRAVERSAL_ADJACENCY_MATRIX_DEFINES_SVH
`define DFS_TRAVERSAL_ADJACENCY_MATRIX_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define DFS_AM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define DFS_AM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/dfs_am_pkg.sv]
// ----------------------------------------------------------------------------
// dfs_am_pkg
// Sizes, control word layout and microcode table of the traversal sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfs_am_pkg;

   localparam int NODES       = 64;
   localparam int STACK_DEPTH = 64;
   localparam int NODE_W      = $clog2(NODES);
   localparam int CNT_W       = $clog2(NODES + 1);
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int SC_W        = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_EDGE_RD,
      OP_EDGE_WR,
      OP_ACK,
      OP_START,
      OP_POP,
      OP_FETCH,
      OP_VISIT,
      OP_SCAN_INIT,
      OP_SCAN,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      W_NONE,
      W_REQ,
      W_OUT,
      W_PEND
   } wait_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_KIND,
      C_BAD,
      C_EMPTY,
      C_SEEN,
      C_MORE
   } cond_type;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_EDGE      = 4'd1,
      ST_EDGE_WR   = 4'd2,
      ST_ACK       = 4'd3,
      ST_START     = 4'd4,
      ST_POPCHK    = 4'd5,
      ST_POP       = 4'd6,
      ST_FETCH     = 4'd7,
      ST_CHECK     = 4'd8,
      ST_VISIT     = 4'd9,
      ST_SCAN_INIT = 4'd10,
      ST_SCAN      = 4'd11,
      ST_LOOP      = 4'd12,
      ST_FINISH    = 4'd13
   } step_type;

   typedef struct packed {
      op_type   op;
      wait_type wait_sel;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   ready;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic kind;
      logic bad;
      logic empty;
      logic seen;
      logic more;
      logic out_free;
      logic pend_valid;
   } stat_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{OP_NONE, W_NONE, C_ALWAYS, ST_IDLE};
      case (step)
         ST_IDLE:      w = '{OP_ACCEPT,    W_REQ,  C_KIND,   ST_START};
         ST_EDGE:      w = '{OP_EDGE_RD,   W_NONE, C_BAD,    ST_ACK};
         ST_EDGE_WR:   w = '{OP_EDGE_WR,   W_NONE, C_NEVER,  ST_IDLE};
         ST_ACK:       w = '{OP_ACK,       W_OUT,  C_ALWAYS, ST_IDLE};
         ST_START:     w = '{OP_START,     W_NONE, C_BAD,    ST_ACK};
         ST_POPCHK:    w = '{OP_NONE,      W_NONE, C_EMPTY,  ST_FINISH};
         ST_POP:       w = '{OP_POP,       W_NONE, C_NEVER,  ST_IDLE};
         ST_FETCH:     w = '{OP_FETCH,     W_NONE, C_NEVER,  ST_IDLE};
         ST_CHECK:     w = '{OP_NONE,      W_NONE, C_SEEN,   ST_SCAN_INIT};
         ST_VISIT:     w = '{OP_VISIT,     W_PEND, C_NEVER,  ST_IDLE};
         ST_SCAN_INIT: w = '{OP_SCAN_INIT, W_NONE, C_NEVER,  ST_IDLE};
         ST_SCAN:      w = '{OP_SCAN,      W_NONE, C_MORE,   ST_SCAN};
         ST_LOOP:      w = '{OP_NONE,      W_NONE, C_ALWAYS, ST_POPCHK};
         ST_FINISH:    w = '{OP_FINISH,    W_OUT,  C_ALWAYS, ST_IDLE};
         default:      w = '{OP_NONE,      W_NONE, C_ALWAYS, ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

[src/dfs_am_if.sv]
// ----------------------------------------------------------------------------
// dfs_am_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dfs_am_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [dfs_am_pkg::NODE_W-1:0] from_node;
   logic [dfs_am_pkg::NODE_W-1:0] to_node;

   modport source (output valid, kind, from_node, to_node, input ready);
   modport sink   (input valid, kind, from_node, to_node, output ready);
endinterface

interface dfs_am_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dfs_am_pkg::NODE_W-1:0] visited_node;
   logic                          last;
   logic                          invalid;
   logic                          overflow_seen;
   logic                          is_visit;

   modport source (output valid, visited_node, last, invalid, overflow_seen, is_visit,
                   input ready);
   modport sink   (input valid, visited_node, last, invalid, overflow_seen, is_visit,
                   output ready);
endinterface

[src/dfs_am_ram.sv]
// ----------------------------------------------------------------------------
// dfs_am_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfs_am_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/dfs_am_seq.sv]
// ----------------------------------------------------------------------------
// dfs_am_seq
// Step counter over the microcode table, with stalls and conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfs_am_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  dfs_am_pkg::stat_type stat,
   output dfs_am_pkg::ctl_type  ctl
);

   dfs_am_pkg::step_type  step_ff;
   dfs_am_pkg::step_type  step_in;
   dfs_am_pkg::ucode_type word;
   logic                  waiting;
   logic                  taken;

   assign word = dfs_am_pkg::ucode_rom(step_ff);

   always_comb begin
      case (word.wait_sel)
         dfs_am_pkg::W_NONE: waiting = 1'b0;
         dfs_am_pkg::W_REQ:  waiting = !stat.req_valid;
         dfs_am_pkg::W_OUT:  waiting = !stat.out_free;
         dfs_am_pkg::W_PEND: waiting = stat.pend_valid && !stat.out_free;
         default:            waiting = 1'b0;
      endcase
   end

   always_comb begin
      case (word.cond)
         dfs_am_pkg::C_NEVER:  taken = 1'b0;
         dfs_am_pkg::C_ALWAYS: taken = 1'b1;
         dfs_am_pkg::C_KIND:   taken = stat.kind;
         dfs_am_pkg::C_BAD:    taken = stat.bad;
         dfs_am_pkg::C_EMPTY:  taken = stat.empty;
         dfs_am_pkg::C_SEEN:   taken = stat.seen;
         dfs_am_pkg::C_MORE:   taken = stat.more;
         default:              taken = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (waiting) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = word.target;
      end else begin
         step_in = dfs_am_pkg::step_type'(step_ff + 4'd1);
      end
   end

   // control outputs
   always_comb begin
      ctl.op    = waiting ? dfs_am_pkg::OP_NONE : word.op;
      ctl.ready = (word.wait_sel == dfs_am_pkg::W_REQ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= dfs_am_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[src/dfs_am_dp.sv]
// ----------------------------------------------------------------------------
// dfs_am_dp
// Datapath: adjacency matrix, node stack, visited marks and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dfs_traversal_adjacency_matrix_defines.svh"

module dfs_am_dp (
   input  logic                             clock,
   input  logic                             reset,
   dfs_am_req_if.sink                       req,
   dfs_am_rsp_if.source                     rsp,
   input  logic [dfs_am_pkg::CNT_W-1:0]     node_limit,
   input  dfs_am_pkg::ctl_type              ctl,
   output dfs_am_pkg::stat_type             stat
);

   localparam int NODES  = dfs_am_pkg::NODES;
   localparam int NODE_W = dfs_am_pkg::NODE_W;
   localparam int CNT_W  = dfs_am_pkg::CNT_W;
   localparam int SP_W   = dfs_am_pkg::SP_W;
   localparam int SC_W   = dfs_am_pkg::SC_W;

   logic [NODE_W-1:0] src_ff, src_in;
   logic [NODE_W-1:0] dst_ff, dst_in;
   logic              invalid_ff, invalid_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NODE_W-1:0] adj_raddr_ff, adj_raddr_in;
   logic [NODES-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [SC_W-1:0]   sc_ff, sc_in;
   logic              ovf_ff, ovf_in;
   logic [NODES-1:0]  visited_ff, visited_in;
   logic [NODES-1:0]  row_valid_ff, row_valid_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [NODE_W-1:0] pend_node_ff, pend_node_in;
   logic              pend_ovf_ff, pend_ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_invalid_ff, rsp_invalid_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              rsp_visit_ff, rsp_visit_in;

   logic              out_free;
   logic              req_bad;
   logic [NODES-1:0]  row_eff;
   logic [NODE_W-1:0] nb;
   logic              push;
   logic              stk_full;

   logic              adj_we, adj_re;
   logic [NODES-1:0]  adj_wdata, adj_rdata;
   logic [NODE_W-1:0] adj_raddr;
   logic              stk_we, stk_re;
   logic [SP_W-1:0]   stk_waddr, stk_raddr;
   logic [NODE_W-1:0] stk_wdata, stk_rdata;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req_bad  = ({1'b0, req.from_node} >= node_limit)
                  || (!req.kind && ({1'b0, req.to_node} >= node_limit));
   assign row_eff  = adj_rdata & {NODES{row_valid_ff[adj_raddr_ff]}};
   assign nb       = NODE_W'(scan_ff - CNT_W'(1));
   assign push     = row_ff[nb] && !visited_ff[nb];
   assign stk_full = (sc_ff >= SC_W'(dfs_am_pkg::STACK_DEPTH));

   assign adj_we    = (ctl.op == dfs_am_pkg::OP_EDGE_WR);
   assign adj_wdata = row_eff | (NODES'(1) << dst_ff);
   assign adj_re    = (ctl.op == dfs_am_pkg::OP_EDGE_RD) || (ctl.op == dfs_am_pkg::OP_FETCH);
   assign adj_raddr = (ctl.op == dfs_am_pkg::OP_FETCH) ? stk_rdata : src_ff;

   assign stk_we    = ((ctl.op == dfs_am_pkg::OP_START) && !invalid_ff)
                   || ((ctl.op == dfs_am_pkg::OP_SCAN) && push && !stk_full);
   assign stk_waddr = (ctl.op == dfs_am_pkg::OP_START) ? '0 : sc_ff[SP_W-1:0];
   assign stk_wdata = (ctl.op == dfs_am_pkg::OP_START) ? src_ff : nb;
   assign stk_re    = (ctl.op == dfs_am_pkg::OP_POP);
   assign stk_raddr = SP_W'(sc_ff - SC_W'(1));

   dfs_am_ram #(
      .WIDTH (NODES),
      .DEPTH (NODES)
   ) u_adj_ram (
      .clock (clock),
      .we    (adj_we),
      .waddr (src_ff),
      .wdata (adj_wdata),
      .re    (adj_re),
      .raddr (adj_raddr),
      .rdata (adj_rdata)
   );

   dfs_am_ram #(
      .WIDTH (NODE_W),
      .DEPTH (dfs_am_pkg::STACK_DEPTH)
   ) u_stk_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   always_comb begin
      src_in         = src_ff;
      dst_in         = dst_ff;
      invalid_in     = invalid_ff;
      cur_in         = cur_ff;
      adj_raddr_in   = adj_raddr_ff;
      row_in         = row_ff;
      scan_in        = scan_ff;
      sc_in          = sc_ff;
      ovf_in         = ovf_ff;
      visited_in     = visited_ff;
      row_valid_in   = row_valid_ff;
      pend_valid_in  = pend_valid_ff;
      pend_node_in   = pend_node_ff;
      pend_ovf_in    = pend_ovf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_node_in    = rsp_node_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_invalid_in = rsp_invalid_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_visit_in   = rsp_visit_ff;

      case (ctl.op)
         dfs_am_pkg::OP_ACCEPT: begin
            src_in     = req.from_node;
            dst_in     = req.to_node;
            invalid_in = req_bad;
         end
         dfs_am_pkg::OP_EDGE_RD: begin
            adj_raddr_in = src_ff;
         end
         dfs_am_pkg::OP_EDGE_WR: begin
            row_valid_in[src_ff] = 1'b1;
         end
         dfs_am_pkg::OP_ACK: begin
            rsp_valid_in   = 1'b1;
            rsp_node_in    = '0;
            rsp_last_in    = 1'b1;
            rsp_invalid_in = invalid_ff;
            rsp_ovf_in     = 1'b0;
            rsp_visit_in   = 1'b0;
         end
         dfs_am_pkg::OP_START: begin
            if (!invalid_ff) begin
               visited_in    = '0;
               ovf_in        = 1'b0;
               sc_in         = SC_W'(1);
               pend_valid_in = 1'b0;
            end
         end
         dfs_am_pkg::OP_POP: begin
            sc_in = sc_ff - SC_W'(1);
         end
         dfs_am_pkg::OP_FETCH: begin
            cur_in       = stk_rdata;
            adj_raddr_in = stk_rdata;
         end
         dfs_am_pkg::OP_VISIT: begin
            visited_in[cur_ff] = 1'b1;
            if (pend_valid_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_node_in    = pend_node_ff;
               rsp_last_in    = 1'b0;
               rsp_invalid_in = 1'b0;
               rsp_ovf_in     = pend_ovf_ff;
               rsp_visit_in   = 1'b1;
            end
            pend_valid_in = 1'b1;
            pend_node_in  = cur_ff;
            pend_ovf_in   = ovf_ff;
         end
         dfs_am_pkg::OP_SCAN_INIT: begin
            row_in  = row_eff;
            scan_in = node_limit;
         end
         dfs_am_pkg::OP_SCAN: begin
            scan_in = scan_ff - CNT_W'(1);
            if (push) begin
               if (stk_full) begin
                  ovf_in = 1'b1;
               end else begin
                  sc_in = sc_ff + SC_W'(1);
               end
            end
         end
         dfs_am_pkg::OP_FINISH: begin
            rsp_valid_in   = 1'b1;
            rsp_node_in    = pend_node_ff;
            rsp_last_in    = 1'b1;
            rsp_invalid_in = 1'b0;
            rsp_ovf_in     = pend_ovf_ff;
            rsp_visit_in   = 1'b1;
            pend_valid_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff         <= '0;
         ovf_ff        <= 1'b0;
         visited_ff    <= '0;
         row_valid_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sc_ff         <= sc_in;
         ovf_ff        <= ovf_in;
         visited_ff    <= visited_in;
         row_valid_ff  <= row_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      invalid_ff     <= invalid_in;
      cur_ff         <= cur_in;
      adj_raddr_ff   <= adj_raddr_in;
      row_ff         <= row_in;
      scan_ff        <= scan_in;
      pend_node_ff   <= pend_node_in;
      pend_ovf_ff    <= pend_ovf_in;
      rsp_node_ff    <= rsp_node_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_invalid_ff <= rsp_invalid_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      rsp_visit_ff   <= rsp_visit_in;
   end

   assign req.ready         = ctl.ready;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.visited_node  = rsp_node_ff;
   assign rsp.last          = rsp_last_ff;
   assign rsp.invalid       = rsp_invalid_ff;
   assign rsp.overflow_seen = rsp_ovf_ff;
   assign rsp.is_visit      = rsp_visit_ff;

   assign stat.req_valid  = req.valid;
   assign stat.kind       = req.kind;
   assign stat.bad        = invalid_ff;
   assign stat.empty      = (sc_ff == '0);
   assign stat.seen       = visited_ff[cur_ff];
   assign stat.more       = (scan_ff > CNT_W'(1));
   assign stat.out_free   = out_free;
   assign stat.pend_valid = pend_valid_ff;

   `DFS_AM_ASSERT_IMP(a_stack_bound, 1'b1, sc_ff <= SC_W'(dfs_am_pkg::STACK_DEPTH), "stack count past depth")
   `DFS_AM_ASSERT_NXT(a_start_init, (ctl.op == dfs_am_pkg::OP_START) && !invalid_ff, (sc_ff == SC_W'(1)) && !ovf_ff && !pend_valid_ff && (visited_ff == '0), "walk not initialized")
   `DFS_AM_ASSERT_IMP(a_visit_fresh, ctl.op == dfs_am_pkg::OP_VISIT, !visited_ff[cur_ff] && (!pend_valid_ff || out_free), "visit of marked node or blocked output")
   `DFS_AM_ASSERT_IMP(a_finish_pend, ctl.op == dfs_am_pkg::OP_FINISH, pend_valid_ff && out_free, "walk ends without a held visit")

endmodule

[src/dfs_traversal_adjacency_matrix.sv]
// ----------------------------------------------------------------------------
// dfs_traversal_adjacency_matrix
// Depth-first walk over a directed graph stored as an adjacency bit matrix.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one word at a time: kind 0 adds edge from_node->to_node,
//   kind 1 starts a walk from from_node. rsp_chan returns the answers; an edge
//   word or a rejected start gives one word, a walk gives one word per visited
//   node in depth-first order, with last set on the final one.
//   csr_we/csr_wdata set node_count; write it only while no word is in flight.
//   Timing: one word in flight at a time. An edge word passes the accept,
//   row read, row write and answer steps; a rejected edge or start goes to
//   the answer right after its check, and the next word is taken in the cycle after.
//   A walk pops a node, fetches its matrix row, visits the node unless it
//   is already seen, and pushes the unvisited neighbors found by the
//   one-neighbor-per-cycle scan of the matrix row. Every pushed node is popped
//   once, so a dense graph pops well over 64 nodes.
//   Each visit is held back until the next visit or the finish step so that
//   last can be set; the final visit leaves once the stack is found empty.
//   Reset clears the matrix (per-row valid bits) and the stack and sets
//   node_count to 64. A stalled rsp_chan holds its word and stops the walk at the
//   next emit; req_chan stays not ready until the current word is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfs_traversal_adjacency_matrix (
   input  logic                         clock,
   input  logic                         reset,
   dfs_am_req_if.sink                   req_chan,
   dfs_am_rsp_if.source                 rsp_chan,
   input  logic                         csr_we,
   input  logic [dfs_am_pkg::CNT_W-1:0] csr_wdata
);

   localparam int CNT_W = dfs_am_pkg::CNT_W;

   logic [CNT_W-1:0]     node_count_ff, node_count_in;
   logic [CNT_W-1:0]     node_limit;
   dfs_am_pkg::ctl_type  ctl;
   dfs_am_pkg::stat_type stat;

   assign node_count_in = csr_we ? csr_wdata : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_W'(dfs_am_pkg::NODES);
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   // clamp to 1..NODES
   always_comb begin
      if (node_count_ff == '0) begin
         node_limit = CNT_W'(1);
      end else if (node_count_ff > CNT_W'(dfs_am_pkg::NODES)) begin
         node_limit = CNT_W'(dfs_am_pkg::NODES);
      end else begin
         node_limit = node_count_ff;
      end
   end

   dfs_am_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   dfs_am_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .node_limit (node_limit),
      .ctl        (ctl),
      .stat       (stat)
   );

endmodule
